/* hdl/xild_pkg.sv */
package xild_pkg;

   localparam int MaxPrefixesDefault = 6;

   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_ESC    = 3'd1;
   localparam logic [2:0] PH_ESC3   = 3'd2;
   localparam logic [2:0] PH_MODRM  = 3'd3;
   localparam logic [2:0] PH_SIB    = 3'd4;
   localparam logic [2:0] PH_DISP   = 3'd5;
   localparam logic [2:0] PH_IMM    = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FAIL  = 2'd1;
   localparam logic [1:0] ST_UNSUP = 2'd2;

   localparam logic [1:0] BR_NONE   = 2'd0;
   localparam logic [1:0] BR_REL8   = 2'd1;
   localparam logic [1:0] BR_NEAR32 = 2'd2;
   localparam logic [1:0] BR_LOOP   = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] insn_length;
      logic [2:0] opcode_offset;
      logic [4:0] disp_offset;
      logic [2:0] disp_size;
      logic       rip_relative;
      logic [1:0] branch_kind;
   } result_type;

endpackage

/* hdl/xild_core.sv */
module xild_core #(
   parameter int MAX_PREFIXES = xild_pkg::MaxPrefixesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            code_byte,
   input  logic                  window_end,
   output logic                  emit,
   output xild_pkg::result_type  result
);

   localparam logic [4:0] MaxPfx = 5'(MAX_PREFIXES);
   localparam logic [1:0] R_MORE = 2'd0;
   localparam logic [1:0] R_DONE = 2'd1;
   localparam logic [1:0] R_FAIL = 2'd2;
   localparam logic [1:0] R_UNSUP = 2'd3;

   logic [2:0] phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic       op16_ff, op16_in, a32_ff, a32_in, rep_ff, rep_in, rexw_ff, rexw_in;
   logic [1:0] map_ff, map_in;
   logic [7:0] opc_ff, opc_in, modrm_ff, modrm_in;
   logic [3:0] brem_ff, brem_in, imm_ff, imm_in;
   logic [4:0] doff_ff, doff_in;
   logic [2:0] dsz_ff, dsz_in;
   logic       rip_ff, rip_in;
   logic [1:0] br_ff, br_in;
   logic [2:0] opos_ff, opos_in;

   logic [1:0] r;
   logic [3:0] immz;
   logic [7:0] b;
   logic [1:0] md;
   logic [2:0] rm;

   always_comb begin
      b = code_byte;
      immz = op16_ff ? 4'd2 : 4'd4;
      md = b[7:6];
      rm = b[2:0];
      pos_in = pos_ff + 5'd1;
      phase_in = phase_ff;
      op16_in = op16_ff; a32_in = a32_ff; rep_in = rep_ff; rexw_in = rexw_ff;
      map_in = map_ff; opc_in = opc_ff; modrm_in = modrm_ff;
      brem_in = brem_ff; imm_in = imm_ff;
      doff_in = doff_ff; dsz_in = dsz_ff; rip_in = rip_ff; br_in = br_ff;
      opos_in = opos_ff;
      r = R_FAIL;
      case (phase_ff)
         xild_pkg::PH_PREFIX: begin
            if (b == 8'h66 || b == 8'h67 || b == 8'hF3 || b == 8'hF0 || b == 8'hF2 ||
                b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 ||
                b == 8'h64 || b == 8'h65 || b[7:4] == 4'h4) begin
               if (b[7:4] == 4'h4) rexw_in = b[3];
               else begin
                  rexw_in = 1'b0;
                  if (b == 8'h66) op16_in = 1'b1;
                  else if (b == 8'h67) a32_in = 1'b1;
                  else if (b == 8'hF3) rep_in = 1'b1;
               end
               r = (pos_in > MaxPfx) ? R_FAIL : R_MORE;
            end else begin
               opos_in = pos_ff[2:0];
               opc_in = b;
               r = R_DONE;
               if (b == 8'h0F) begin
                  map_in = 2'd1; phase_in = xild_pkg::PH_ESC; r = R_MORE;
               end else if (b <= 8'h3F) begin
                  if (rm == 3'd4) imm_in = 4'd1;
                  else if (rm == 3'd5) imm_in = immz;
                  else if (rm >= 3'd6) r = R_UNSUP;
                  else begin
                     imm_in = 4'd0; phase_in = xild_pkg::PH_MODRM; r = R_MORE;
                  end
               end else if ((b >= 8'h50 && b <= 8'h5F) || (b >= 8'h90 && b <= 8'h99) ||
                  (b >= 8'h9B && b <= 8'h9F) || b == 8'hC3 || b == 8'hC9 || b == 8'hCB ||
                  b == 8'hCC || b == 8'hCF || b == 8'hF1 || b == 8'hF4 || b == 8'hF5 ||
                  (b >= 8'hF8 && b <= 8'hFD) || (b >= 8'h6C && b <= 8'h6F) ||
                  (b >= 8'hA4 && b <= 8'hA7) || (b >= 8'hAA && b <= 8'hAF) ||
                  (b >= 8'hEC && b <= 8'hEF)) begin
                  r = R_DONE;
               end else if (b == 8'h60 || b == 8'h61 || b == 8'h62 || b == 8'h82 ||
                  b == 8'h9A || b == 8'hC4 || b == 8'hC5 || b == 8'hCE || b == 8'hD4 ||
                  b == 8'hD5 || b == 8'hEA) begin
                  r = R_UNSUP;
               end else if (b == 8'h63 || (b >= 8'h84 && b <= 8'h8F) ||
                  (b >= 8'hD0 && b <= 8'hD3) || (b >= 8'hD8 && b <= 8'hDF) ||
                  b == 8'hFE || b == 8'hFF || b == 8'hF6 || b == 8'hF7) begin
                  imm_in = 4'd0; phase_in = xild_pkg::PH_MODRM; r = R_MORE;
               end else if ((b >= 8'h70 && b <= 8'h7F) || b == 8'hEB) begin
                  doff_in = pos_in; dsz_in = 3'd1; rip_in = 1'b0;
                  br_in = xild_pkg::BR_REL8;
                  brem_in = 4'd1;
               end else if (b >= 8'hE0 && b <= 8'hE3) begin
                  doff_in = pos_in; dsz_in = 3'd1; rip_in = 1'b0;
                  br_in = xild_pkg::BR_LOOP;
                  brem_in = 4'd1;
               end else if (b == 8'hE8 || b == 8'hE9) begin
                  doff_in = pos_in; dsz_in = 3'd4; rip_in = 1'b0;
                  br_in = xild_pkg::BR_NEAR32;
                  brem_in = 4'd4;
               end else if (b >= 8'hB8 && b <= 8'hBF) begin
                  imm_in = rexw_ff ? 4'd8 : immz;
               end else if (b >= 8'hA0 && b <= 8'hA3) begin
                  imm_in = a32_ff ? 4'd4 : 4'd8;
               end else if ((b >= 8'hB0 && b <= 8'hB7) || (b >= 8'hE4 && b <= 8'hE7) ||
                  b == 8'h6A || b == 8'hA8 || b == 8'hCD) begin
                  imm_in = 4'd1;
               end else if (b == 8'h68 || b == 8'hA9) begin
                  imm_in = immz;
               end else if (b == 8'hC2 || b == 8'hCA) begin
                  imm_in = 4'd2;
               end else if (b == 8'hC8) begin
                  imm_in = 4'd3;
               end else if (b == 8'h6B || b == 8'h80 || b == 8'h83 || b == 8'hC0 ||
                  b == 8'hC1 || b == 8'hC6) begin
                  imm_in = 4'd1; phase_in = xild_pkg::PH_MODRM; r = R_MORE;
               end else if (b == 8'h69 || b == 8'h81 || b == 8'hC7) begin
                  imm_in = immz; phase_in = xild_pkg::PH_MODRM; r = R_MORE;
               end else begin
                  r = R_FAIL;
               end
            end
         end
         xild_pkg::PH_ESC: begin
            opc_in = b;
            r = R_MORE;
            if (b == 8'h38 || b == 8'h3A) begin
               map_in = (b == 8'h38) ? 2'd2 : 2'd3; phase_in = xild_pkg::PH_ESC3;
            end else if (b[7:4] == 4'h8) begin
               doff_in = pos_in; dsz_in = 3'd4; rip_in = 1'b0;
               br_in = xild_pkg::BR_NEAR32;
               brem_in = 4'd4; r = R_DONE;
            end else if ((b >= 8'h05 && b <= 8'h09) || b == 8'h0B || b == 8'h0E ||
               (b >= 8'h30 && b <= 8'h35) || b == 8'h77 || b == 8'hA2 || b == 8'hAA ||
               (b >= 8'hC8 && b <= 8'hCF)) begin
               r = R_DONE;
            end else if ((b >= 8'h70 && b <= 8'h73) || b == 8'hA4 || b == 8'hAC ||
               b == 8'hBA || b == 8'hC2 || (b >= 8'hC4 && b <= 8'hC6) || b == 8'h0F) begin
               imm_in = 4'd1; phase_in = xild_pkg::PH_MODRM;
            end else if (b == 8'hB8 && !rep_ff) begin
               r = R_UNSUP;
            end else begin
               imm_in = 4'd0; phase_in = xild_pkg::PH_MODRM;
            end
         end
         xild_pkg::PH_ESC3: begin
            opc_in = b;
            imm_in = (map_ff == 2'd3) ? 4'd1 : 4'd0;
            phase_in = xild_pkg::PH_MODRM;
            r = R_MORE;
         end
         xild_pkg::PH_MODRM: begin
            modrm_in = b;
            if (map_ff == 2'd0 && (opc_ff == 8'hF6 || opc_ff == 8'hF7) && b[5:4] == 2'd0)
               imm_in = (opc_ff == 8'hF6) ? 4'd1 : immz;
            r = R_DONE;
            if (md == 2'd3) r = R_DONE;
            else if (rm == 3'd4) begin phase_in = xild_pkg::PH_SIB; r = R_MORE; end
            else begin
               if (md == 2'd0 && rm == 3'd5) begin
                  doff_in = pos_in; dsz_in = 3'd4; rip_in = 1'b1;
                  br_in = xild_pkg::BR_NONE;
                  brem_in = 4'd4;
               end else if (md != 2'd0) begin
                  doff_in = pos_in; dsz_in = md[0] ? 3'd1 : 3'd4; rip_in = 1'b0;
                  br_in = xild_pkg::BR_NONE; brem_in = md[0] ? 4'd1 : 4'd4;
               end else brem_in = 4'd0;
            end
         end
         xild_pkg::PH_SIB: begin
            r = R_DONE;
            if ((modrm_ff[7:6] == 2'd0 && rm == 3'd5) || modrm_ff[7:6] == 2'd2) begin
               doff_in = pos_in; dsz_in = 3'd4; rip_in = 1'b0; br_in = xild_pkg::BR_NONE;
               brem_in = 4'd4;
            end else if (modrm_ff[7:6] == 2'd1) begin
               doff_in = pos_in; dsz_in = 3'd1; rip_in = 1'b0; br_in = xild_pkg::BR_NONE;
               brem_in = 4'd1;
            end else brem_in = 4'd0;
         end
         xild_pkg::PH_DISP: begin
            if (brem_ff != 4'd0) brem_in = brem_ff - 4'd1;
            r = R_DONE;
         end
         xild_pkg::PH_IMM: begin
            if (imm_ff != 4'd0) imm_in = imm_ff - 4'd1;
            r = R_DONE;
         end
         default: r = R_FAIL;
      endcase
      // finish: move on to what is still due
      if (r == R_DONE) begin
         if (brem_in != 4'd0) begin phase_in = xild_pkg::PH_DISP; r = R_MORE; end
         else if (imm_in != 4'd0) begin phase_in = xild_pkg::PH_IMM; r = R_MORE; end
      end
      if (r == R_MORE && window_end) r = R_FAIL;
      emit = (r != R_MORE);
      result = '0;
      if (r == R_DONE) begin
         result.insn_length = pos_in;
         result.opcode_offset = opos_in;
         result.disp_offset = doff_in;
         result.disp_size = dsz_in;
         result.rip_relative = rip_in;
         result.branch_kind = br_in;
      end else begin
         result.status = (r == R_UNSUP) ? xild_pkg::ST_UNSUP : xild_pkg::ST_FAIL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && emit)) begin
         phase_ff <= xild_pkg::PH_PREFIX; pos_ff <= '0;
         op16_ff <= 1'b0; a32_ff <= 1'b0; rep_ff <= 1'b0; rexw_ff <= 1'b0;
         map_ff <= '0; opc_ff <= '0; modrm_ff <= '0; brem_ff <= '0; imm_ff <= '0;
         doff_ff <= '0; dsz_ff <= '0; rip_ff <= 1'b0; br_ff <= '0; opos_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in;
         op16_ff <= op16_in; a32_ff <= a32_in; rep_ff <= rep_in; rexw_ff <= rexw_in;
         map_ff <= map_in; opc_ff <= opc_in; modrm_ff <= modrm_in;
         brem_ff <= brem_in; imm_ff <= imm_in;
         doff_ff <= doff_in; dsz_ff <= dsz_in; rip_ff <= rip_in; br_ff <= br_in;
         opos_ff <= opos_in;
      end
   end

   a_phase_ok: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 3'd7) else $error("bad phase");
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      emit && result.status != xild_pkg::ST_OK |-> result.insn_length == 5'd0)
      else $error("fail with length");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> pos_ff == 5'd0) else $error("no restart");

endmodule

/* hdl/x64_instruction_length_decoder_top.sv */
// Channel  Dir  Word
// req      in   tdata[7:0] code_byte, tlast window_end
// rsp      out  tdata[23:0] status..branch_kind
// One byte per cycle while not stalled; a byte is decoded from the input
// register and the result is registered, so a result is valid once its final
// byte has passed through the input register and the result register.
// Synchronous active-high reset clears all decode state.
// Input stalls only while a finishing byte waits on a full result register.
module x64_instruction_length_decoder_top #(
   parameter int MAX_PREFIXES = xild_pkg::MaxPrefixesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   input  logic        req_tlast,   // window_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status, insn_length, opcode_offset,
                                    // disp_offset, disp_size, rip_relative,
                                    // branch_kind, 3 zero bits
);

   logic                 in_v_ff;
   logic [7:0]           in_b_ff;
   logic                 in_l_ff;
   logic                 step, emit;
   xild_pkg::result_type res;
   logic                 out_v_ff;
   logic [23:0]          out_d_ff;

   // core step stalls only when it would emit into a full result register
   assign step = in_v_ff && !(emit && out_v_ff && !rsp_tready);
   assign req_tready = !in_v_ff || step;

   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else if (req_tready) in_v_ff <= req_tvalid;
      if (req_tready) begin
         in_b_ff <= req_tdata;
         in_l_ff <= req_tlast;
      end
   end

   xild_core #(.MAX_PREFIXES(MAX_PREFIXES)) u_core (
      .clock(clock), .reset(reset), .step(step), .code_byte(in_b_ff),
      .window_end(in_l_ff), .emit(emit), .result(res));

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (step && emit) out_v_ff <= 1'b1;
      else if (rsp_tready) out_v_ff <= 1'b0;
      if (step && emit)
         out_d_ff <= {3'b000, res.branch_kind, res.rip_relative, res.disp_size,
                      res.disp_offset, res.opcode_offset, res.insn_length, res.status};
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_d_ff;

endmodule
